// ----- src/dedup_error_log_fifo_macros.svh -----
// Assertion macros shared by the error log.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DEDUP_ERROR_LOG_FIFO_MACROS_SVH
`define DEDUP_ERROR_LOG_FIFO_MACROS_SVH

// Same-cycle implication.
`define DELF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DELF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/delf_pkg.sv -----
package delf_pkg;

  localparam int LogDepth = 8;
  localparam int CntW     = $clog2(LogDepth + 1);

  localparam int CodeW   = 8;
  localparam int AddrW   = 32;
  localparam int RidxW   = 6;
  localparam int EcountW = 7;

  localparam logic CmdRecord = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef struct packed {
    logic             command;
    logic [CodeW-1:0] error_code;
    logic [AddrW-1:0] instruction_address;
    logic [RidxW-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic               already_recorded;
    logic               oldest_dropped;
    logic [EcountW-1:0] entry_count;
    logic               entry_valid;
    logic [CodeW-1:0]   entry_code;
    logic [AddrW-1:0]   entry_offset;
  } out_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [AddrW-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- src/delf_cell.sv -----
// One log slot. It takes a fresh entry on load, its neighbor's entry on shift,
// and otherwise keeps what it holds.
module delf_cell (
  input  logic                clk_i,
  input  delf_pkg::cell_ctrl_t ctrl_i,
  input  delf_pkg::entry_t    nbr_i,
  input  delf_pkg::entry_t    new_i,
  output delf_pkg::entry_t    entry_o
);

  delf_pkg::entry_t entry_q;
  delf_pkg::entry_t entry_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- src/dedup_error_log_fifo.sv -----
// A transaction accepted in the idle state passes through the scan state and then the update
// state, which writes its result into the output register once the previous result has left it.
// The input stalls outside the idle state, so a new transaction waits until the update is done.
// Reset (rst_ni low, asynchronous) empties the log, clears program_base and the output valid;
// the stored entries themselves are not cleared, and none is read before it is written.
`include "dedup_error_log_fifo_macros.svh"

module dedup_error_log_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  delf_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output delf_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [delf_pkg::AddrW-1:0]       cfg_data_i
);

  // The log lives in a row of cells, cell 0 holding the oldest entry. To search
  // or read, the whole row rotates toward cell 0 once per cycle in the scan state,
  // one step per cell, so entry k passes through cell 0 at scan step k and the
  // row ends up in its original order. The update state then appends the new
  // entry into the cell at the current count, or, with the log full, shifts the
  // row by one and loads the new entry into the last cell.

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;

  localparam logic [delf_pkg::CntW-1:0] CntFull  = delf_pkg::CntW'(delf_pkg::LogDepth);
  localparam logic [delf_pkg::CntW-1:0] StepLast = delf_pkg::CntW'(delf_pkg::LogDepth - 1);

  logic [1:0]                   state_q, state_d;
  logic [delf_pkg::CntW-1:0]    step_q, step_d;
  logic [delf_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [delf_pkg::AddrW-1:0]   base_q;

  // Transaction being worked on.
  logic                         cmd_q;
  logic [delf_pkg::CodeW-1:0]   code_q;
  logic [delf_pkg::AddrW-1:0]   offset_q;
  logic [delf_pkg::RidxW-1:0]   ridx_q;

  // Scan results.
  logic                         found_q, found_d;
  delf_pkg::entry_t             rd_q, rd_d;

  logic                         out_valid_q, out_valid_d;
  delf_pkg::out_t               out_q, out_d;

  delf_pkg::entry_t             cell_data [delf_pkg::LogDepth];
  delf_pkg::cell_ctrl_t         cell_ctrl [delf_pkg::LogDepth];
  delf_pkg::entry_t             new_entry;

  logic                         in_fire;
  logic                         out_free;
  logic                         do_update;
  logic                         do_insert;
  logic                         is_full;
  logic [delf_pkg::EcountW-1:0] step_ext, cnt_ext, ridx_ext;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // The output register is free when it is empty or being emptied this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_update = (state_q == StUpdate) && out_free;
  assign is_full   = (cnt_q == CntFull);
  assign do_insert = do_update && (cmd_q == delf_pkg::CmdRecord) && !found_q;

  assign step_ext = delf_pkg::EcountW'(step_q);
  assign cnt_ext  = delf_pkg::EcountW'(cnt_q);
  assign ridx_ext = delf_pkg::EcountW'(ridx_q);

  assign new_entry.code   = code_q;
  assign new_entry.offset = offset_q;

  // Cell row. The last cell's neighbor is cell 0, which closes the ring for rotation.
  for (genvar gi = 0; gi < delf_pkg::LogDepth; gi++) begin : g_cell
    always_comb begin
      cell_ctrl[gi].shift = 1'b0;
      cell_ctrl[gi].load  = 1'b0;
      if (state_q == StScan) begin
        cell_ctrl[gi].shift = 1'b1;
      end else if (do_insert) begin
        if (is_full) begin
          cell_ctrl[gi].shift = (gi < delf_pkg::LogDepth - 1);
          cell_ctrl[gi].load  = (gi == delf_pkg::LogDepth - 1);
        end else begin
          cell_ctrl[gi].load  = (delf_pkg::CntW'(gi) == cnt_q);
        end
      end
    end

    delf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[gi]),
      .nbr_i   (cell_data[(gi + 1) % delf_pkg::LogDepth]),
      .new_i   (new_entry),
      .entry_o (cell_data[gi])
    );
  end

  // Sequencer and scan.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StScan;
          step_d  = '0;
          found_d = 1'b0;
        end
      end
      StScan: begin
        // Only entries below the count take part in the search.
        if ((step_ext < cnt_ext) && (cell_data[0].offset == offset_q)) begin
          found_d = 1'b1;
        end
        if (step_ext == ridx_ext) begin
          rd_d = cell_data[0];
        end
        step_d = step_q + 1'b1;
        if (step_q == StepLast) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (out_free) begin
          if (do_insert && !is_full) begin
            cnt_d = cnt_q + 1'b1;
          end
          out_d.already_recorded = (cmd_q == delf_pkg::CmdRecord) && found_q;
          out_d.oldest_dropped   = do_insert && is_full;
          out_d.entry_count      = delf_pkg::EcountW'(cnt_d);
          out_d.entry_valid      = (cmd_q == delf_pkg::CmdRead) && (ridx_ext < cnt_ext);
          out_d.entry_code       = out_d.entry_valid ? rd_q.code : '0;
          out_d.entry_offset     = out_d.entry_valid ? rd_q.offset : '0;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    out_q <= out_d;
    if (in_fire) begin
      cmd_q    <= in_data_i.command;
      code_q   <= in_data_i.error_code;
      offset_q <= in_data_i.instruction_address - base_q;
      ridx_q   <= in_data_i.read_index;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DELF_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_q == StScan, "accept without scan")
  `DELF_ASSERT_NEXT(a_update_gives_result, do_update, out_valid_q, "update without result")
  `DELF_ASSERT_NEXT(a_full_stays_full, do_insert && is_full, cnt_q == CntFull, "count changed")
  `DELF_ASSERT_NOW(a_count_bounded, state_q != StIdle, cnt_q <= CntFull, "count above depth")

endmodule

// ----- dv/tb_dedup_error_log_fifo.sv -----
`timescale 1ns / 100ps

// Testbench for the deduplicating error log.
//
// Commands go in one at a time through the valid/stall input channel. Each accepted
// transaction is run through a local model of the log at the moment it is accepted,
// and the result it must produce is queued. A checker on the output channel pops the
// oldest queued result for every accepted output transaction and compares it field by
// field. The program base is rewritten between phases, only once the log has drained.
module tb_dedup_error_log_fifo;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  delf_pkg::in_t                 in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  delf_pkg::out_t                out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [delf_pkg::AddrW-1:0]    cfg_data_i;

  dedup_error_log_fifo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 8 ns clock period.
  always #4 clk_i = ~clk_i;

  // Local copy of the log: entry 0 is the oldest one, log_fill counts valid entries.
  logic [delf_pkg::CodeW-1:0] log_codes   [delf_pkg::LogDepth];
  logic [delf_pkg::AddrW-1:0] log_offsets [delf_pkg::LogDepth];
  int                         log_fill;
  logic [delf_pkg::AddrW-1:0] prog_base;

  // Results still owed by the block, oldest first.
  delf_pkg::out_t pending_results[$];

  int err_cnt;
  // When idle_on is low neither side inserts gaps. long_hold_req asks the receiver
  // to stall for a long stretch so that results back up and the input stalls.
  bit idle_on;
  bit long_hold_req;

  // Applies one command to the local log and returns the result it must produce.
  function automatic delf_pkg::out_t log_apply(delf_pkg::in_t item);
    logic [delf_pkg::AddrW-1:0] ofs;
    delf_pkg::out_t             res;
    bit                         hit;
    res = '0;
    hit = 1'b0;
    if (item.command == delf_pkg::CmdRecord) begin
      // The offset wraps modulo 2^32 when the address lies below the base.
      ofs = item.instruction_address - prog_base;
      for (int i = 0; i < log_fill; i++) begin
        if (log_offsets[i] == ofs) begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        // A duplicate offset keeps the stored code, whatever the new code is.
        res.already_recorded = 1'b1;
      end else if (log_fill >= delf_pkg::LogDepth) begin
        // Full log: the oldest entry falls out and the new one goes last.
        for (int i = 0; i < delf_pkg::LogDepth - 1; i++) begin
          log_codes[i]   = log_codes[i + 1];
          log_offsets[i] = log_offsets[i + 1];
        end
        log_codes[delf_pkg::LogDepth - 1]   = item.error_code;
        log_offsets[delf_pkg::LogDepth - 1] = ofs;
        res.oldest_dropped = 1'b1;
      end else begin
        log_codes[log_fill]   = item.error_code;
        log_offsets[log_fill] = ofs;
        log_fill++;
      end
    end else begin
      // A read past the fill level reports an invalid entry with zero fields.
      if (int'(item.read_index) < log_fill) begin
        res.entry_valid  = 1'b1;
        res.entry_code   = log_codes[item.read_index];
        res.entry_offset = log_offsets[item.read_index];
      end
    end
    res.entry_count = delf_pkg::EcountW'(log_fill);
    return res;
  endfunction

  function automatic delf_pkg::in_t make_cmd(logic cmd, logic [delf_pkg::CodeW-1:0] code,
                                             logic [delf_pkg::AddrW-1:0] addr,
                                             logic [delf_pkg::RidxW-1:0] idx);
    delf_pkg::in_t item;
    item.command             = cmd;
    item.error_code          = code;
    item.instruction_address = addr;
    item.read_index          = idx;
    return item;
  endfunction

  // Random command. Most record addresses come from a small pool of offsets above the
  // current base so that the log fills, overflows and sees duplicates; the rest are
  // fully random. Reads mostly aim at or just past the valid range.
  function automatic delf_pkg::in_t random_cmd();
    logic                       cmd;
    logic [delf_pkg::AddrW-1:0] addr;
    logic [delf_pkg::RidxW-1:0] idx;
    cmd = ($urandom_range(0, 9) < 4) ? delf_pkg::CmdRead : delf_pkg::CmdRecord;
    if ($urandom_range(0, 9) < 7) begin
      addr = prog_base + delf_pkg::AddrW'($urandom_range(0, 23) * 4);
    end else begin
      addr = $urandom;
    end
    if ($urandom_range(0, 9) < 8) begin
      idx = delf_pkg::RidxW'($urandom_range(0, delf_pkg::LogDepth));
    end else begin
      idx = delf_pkg::RidxW'($urandom_range(0, 63));
    end
    return make_cmd(cmd, delf_pkg::CodeW'($urandom), addr, idx);
  endfunction

  // Sends one transaction. Called and returns at a falling edge; valid stays high on
  // return so that back-to-back items never drop it within one time step.
  task automatic issue_command(delf_pkg::in_t item);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(log_apply(item));
    @(negedge clk_i);
  endtask

  // Waits until every owed result has come out, then gives the block time to settle.
  task automatic drain_log();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (delf_pkg::LogDepth + 4) @(negedge clk_i);
  endtask

  // Writes the program base while the block is idle.
  task automatic write_base(logic [delf_pkg::AddrW-1:0] base);
    drain_log();
    cfg_valid_i = 1'b1;
    cfg_data_i  = base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    prog_base = base;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Empty reads, field extremes, duplicates, overflow and an address below the base.
  task automatic test_directed();
    write_base('0);
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'h00, 32'h0000_0000, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    // Same offset with a different code: the stored code must stay.
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'h5A, 32'h0000_0000, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0, 6'd0));
    for (int k = 1; k <= delf_pkg::LogDepth - 2; k++) begin
      issue_command(make_cmd(delf_pkg::CmdRecord, delf_pkg::CodeW'(k),
                             delf_pkg::AddrW'(k * 16), 6'd0));
    end
    // The log is full now, so the next new offset pushes out the oldest entry.
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'hA5, 32'h8000_0000, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0,
                           delf_pkg::RidxW'(delf_pkg::LogDepth - 1)));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0,
                           delf_pkg::RidxW'(delf_pkg::LogDepth)));
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'h11, 32'hFFFF_FFFF, 6'd0));
    // With a nonzero base an address below it wraps to a large offset.
    write_base(32'h1000_0000);
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'h22, 32'h0000_0004, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0,
                           delf_pkg::RidxW'(delf_pkg::LogDepth - 1)));
    issue_command(make_cmd(delf_pkg::CmdRecord, 8'h33, 32'h1000_0000, 6'd0));
    issue_command(make_cmd(delf_pkg::CmdRead, 8'h00, 32'h0,
                           delf_pkg::RidxW'(delf_pkg::LogDepth - 1)));
  endtask

  // Random traffic under several program bases, the extremes among them.
  task automatic test_base_settings();
    logic [delf_pkg::AddrW-1:0] bases[4];
    bases = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0};
    bases[3] = $urandom;
    foreach (bases[b]) begin
      write_base(bases[b]);
      repeat (300) issue_command(random_cmd());
    end
  endtask

  // The receiver stalls for a long stretch while commands keep coming.
  task automatic test_full_backpressure();
    long_hold_req = 1'b1;
    repeat (20) issue_command(random_cmd());
  endtask

  // Closing stretch at full rate, with no gaps on either side.
  task automatic test_no_idle();
    write_base($urandom);
    idle_on = 1'b0;
    repeat (360) issue_command(random_cmd());
  endtask

  // Receiver: random stall bursts, plus the long hold when one is asked for.
  initial begin
    int hold_cycles;
    int burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i = 1'b1;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge clk_i);
        out_stall_i   = 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall_i = 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [delf_pkg::AddrW-1:0] want,
                             logic [delf_pkg::AddrW-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Every accepted output transaction is matched against the oldest owed result.
  always @(posedge clk_i) begin : result_check
    delf_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        check_field("already_recorded", delf_pkg::AddrW'(want.already_recorded),
                    delf_pkg::AddrW'(out_data_o.already_recorded));
        check_field("oldest_dropped", delf_pkg::AddrW'(want.oldest_dropped),
                    delf_pkg::AddrW'(out_data_o.oldest_dropped));
        check_field("entry_count", delf_pkg::AddrW'(want.entry_count),
                    delf_pkg::AddrW'(out_data_o.entry_count));
        check_field("entry_valid", delf_pkg::AddrW'(want.entry_valid),
                    delf_pkg::AddrW'(out_data_o.entry_valid));
        check_field("entry_code", delf_pkg::AddrW'(want.entry_code),
                    delf_pkg::AddrW'(out_data_o.entry_code));
        check_field("entry_offset", want.entry_offset, out_data_o.entry_offset);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    err_cnt       = 0;
    log_fill      = 0;
    prog_base     = '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_base_settings();
    test_full_backpressure();
    test_no_idle();

    // An unexpected extra result shows up as a failure in the checker.
    drain_log();
    repeat (2 * delf_pkg::LogDepth + 4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Generous limit: far beyond the slowest correct run with every gap and stall.
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
